@@ rtl/core/hbbc_pkg.sv @@
// Package for the hashed block buffer cache core: sizes, codes, entry and
// command/status types shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps
package hbbc_pkg;
  localparam int unsigned SETS      = 13;
  localparam int unsigned WAYS      = 2;
  localparam int unsigned ENTRIES   = SETS * WAYS;
  localparam int unsigned SET_W     = $clog2(SETS);
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W    = WAY_W;
  localparam int unsigned HANDLE_W  = 5;
  localparam int unsigned SETROW_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam logic [7:0]  COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_BUF = 2'd1,
    ST_COUNT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0]        dev;
    logic [23:0]       blk;
    logic [7:0]        cnt;
    logic              valid;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic load;   // capture request and read set row
    logic exec;   // compute result and write set row back
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;
endpackage

@@ rtl/core/hashed_block_buffer_cache_core.sv @@
// Top level of the hashed block buffer cache core: streaming ports around
// controller and datapath. Depends on hbbc_pkg, hbbc_ctrl, hbbc_datapath.
`timescale 1ns / 1ps
// Each request is loaded (set row read), then executed (row write-back and
// result register) and then waits in the output register until taken. One
// request is in flight at a time: a new one is accepted only once the result
// has been taken. No clearing pass is needed.
module hashed_block_buffer_cache_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], device[9:2], block_number[33:10], buffer_handle[38:34], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // handle_out[4:0], hit[5], needs_read[6], ref_count_out[14:7], status[16:15]
  output logic [23:0] m_axis_tdata
);
  hbbc_pkg::cmd_t  cmd;
  hbbc_pkg::stat_t stat;
  logic [16:0] res;

  hbbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .stat_i(stat)
  );

  hbbc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .req_i(s_axis_tdata), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res};
endmodule

@@ rtl/core/hbbc_datapath.sv @@
// Datapath: request register, set-row memory, mod-13 set index, hit/victim
// logic and result register. Depends on hbbc_pkg.
`timescale 1ns / 1ps
module hbbc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hbbc_pkg::cmd_t                cmd_i,
  output hbbc_pkg::stat_t               stat_o,
  input  logic [39:0]                   req_i,
  output logic [16:0]                   res_o
);
  localparam int unsigned HW = hbbc_pkg::HANDLE_W;

  // one row per set, all ways side by side
  hbbc_pkg::entry_t [hbbc_pkg::WAYS-1:0] mem_q [hbbc_pkg::SETS];
  logic [hbbc_pkg::SETS-1:0] row_init_q;  // row still at reset contents
  hbbc_pkg::entry_t [hbbc_pkg::WAYS-1:0] row_q, row_rd, row_new;
  logic [1:0]  op_q;
  logic [7:0]  dev_q;
  logic [23:0] blk_q;
  logic [HW-1:0] hnd_q;
  logic [hbbc_pkg::SETROW_W-1:0] set_q;
  logic [16:0] res_q;
  logic [16:0] res_d;
  logic        done_q;

  // set index of the incoming request; the folds hold for 13 sets:
  // 4096 = 1, 64 = -1 and 16 = 3 (mod 13)
  logic [13:0] fold1;
  logic [12:0] fold2;
  logic [7:0]  fold3;
  logic [5:0]  fold4, set_rem;
  logic [hbbc_pkg::SETROW_W-1:0] get_set, hnd_set, req_set;
  logic [hbbc_pkg::WAY_W-1:0] hnd_way;
  logic hnd_bad;
  assign fold1 = 14'(req_i[9:2]) + 14'(req_i[21:10]) + 14'(req_i[33:22]);
  assign fold2 = 13'(fold1[13:12]) + 13'(fold1[11:0]);
  assign fold3 = 8'(fold2[5:0]) + 8'd65 - 8'(fold2[12:6]);
  assign fold4 = 6'(fold3[7:4]) + {1'b0, fold3[7:4], 1'b0} + 6'(fold3[3:0]);
  always_comb begin
    if (fold4 >= 6'(2 * hbbc_pkg::SETS))  set_rem = fold4 - 6'(2 * hbbc_pkg::SETS);
    else if (fold4 >= 6'(hbbc_pkg::SETS)) set_rem = fold4 - 6'(hbbc_pkg::SETS);
    else                                  set_rem = fold4;
  end
  assign get_set = hbbc_pkg::SETROW_W'(set_rem);
  assign hnd_set = hbbc_pkg::SETROW_W'(req_i[38:34] / 5'(hbbc_pkg::WAYS));
  assign hnd_bad = req_i[38:34] >= 5'(hbbc_pkg::ENTRIES);
  assign req_set = (req_i[1:0] == hbbc_pkg::OP_GET) ? get_set :
                   (hnd_bad ? '0 : hnd_set);
  assign hnd_way = hbbc_pkg::WAY_W'(hnd_q % 5'(hbbc_pkg::WAYS));

  // reset view of a row
  always_comb begin
    for (int w = 0; w < hbbc_pkg::WAYS; w++) begin
      row_rd[w] = '0;
      row_rd[w].rank = hbbc_pkg::RANK_W'(w);
    end
  end

  // request capture, row read, and row/result write on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i[1:0];
      dev_q <= req_i[9:2];
      blk_q <= req_i[33:10];
      hnd_q <= req_i[38:34];
      set_q <= req_set;
      row_q <= row_init_q[req_set] ? row_rd : mem_q[req_set];
    end
    if (cmd_i.exec) begin
      mem_q[set_q] <= row_new;
      res_q        <= res_d;
    end
  end

  // result held valid from execute until the next request is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '1;
      done_q     <= 1'b0;
    end else begin
      if (cmd_i.exec)      done_q <= 1'b1;
      else if (cmd_i.load) done_q <= 1'b0;
      if (cmd_i.exec) row_init_q[set_q] <= 1'b0;
    end
  end

  // hit / victim selection and row update
  logic hit_f, vic_f;
  logic [hbbc_pkg::WAY_W-1:0] hit_w, vic_w;
  logic [hbbc_pkg::RANK_W-1:0] r0;
  logic [7:0] c;
  logic bad;
  always_comb begin
    row_new = row_q;
    res_d   = '0;
    hit_f = 1'b0; vic_f = 1'b0; hit_w = '0; vic_w = '0; r0 = '0; c = '0;
    bad = hnd_q >= 5'(hbbc_pkg::ENTRIES);
    for (int w = 0; w < hbbc_pkg::WAYS; w++) begin
      if (row_q[w].dev == dev_q && row_q[w].blk == blk_q &&
          (!hit_f || row_q[w].rank > row_q[hit_w].rank)) begin
        hit_f = 1'b1; hit_w = hbbc_pkg::WAY_W'(w);
      end
      if (row_q[w].cnt == 8'd0 && (!vic_f || row_q[w].rank < row_q[vic_w].rank)) begin
        vic_f = 1'b1; vic_w = hbbc_pkg::WAY_W'(w);
      end
    end
    if (op_q == hbbc_pkg::OP_GET) begin
      if (hit_f) begin
        c = row_q[hit_w].cnt;
        res_d[16:15] = hbbc_pkg::ST_OK;
        if (c == hbbc_pkg::COUNT_MAX) res_d[16:15] = hbbc_pkg::ST_COUNT;
        else c = c + 8'd1;
        row_new[hit_w].cnt   = c;
        row_new[hit_w].valid = 1'b1;
        res_d[4:0]  = HW'(32'(set_q) * hbbc_pkg::WAYS + 32'(hit_w));
        res_d[5]    = 1'b1;
        res_d[6]    = ~row_q[hit_w].valid;
        res_d[14:7] = c;
      end else if (vic_f) begin
        row_new[vic_w].dev   = dev_q;
        row_new[vic_w].blk   = blk_q;
        row_new[vic_w].cnt   = 8'd1;
        row_new[vic_w].valid = 1'b1;
        res_d[4:0]  = HW'(32'(set_q) * hbbc_pkg::WAYS + 32'(vic_w));
        res_d[6]    = 1'b1;
        res_d[14:7] = 8'd1;
      end else begin
        res_d[16:15] = hbbc_pkg::ST_NO_BUF;
      end
    end else if (bad) begin
      res_d[4:0]   = hnd_q;
      res_d[16:15] = hbbc_pkg::ST_NO_BUF;
    end else begin
      c = row_q[hnd_way].cnt;
      res_d[4:0] = hnd_q;
      if (op_q == hbbc_pkg::OP_PIN) begin
        if (c == hbbc_pkg::COUNT_MAX) res_d[16:15] = hbbc_pkg::ST_COUNT;
        else c = c + 8'd1;
      end else if (c == 8'd0) begin
        res_d[16:15] = hbbc_pkg::ST_COUNT;
      end else begin
        c = c - 8'd1;
        if (op_q == hbbc_pkg::OP_RELEASE && c == 8'd0) begin
          r0 = row_q[hnd_way].rank;
          for (int w = 0; w < hbbc_pkg::WAYS; w++)
            if (row_q[w].rank > r0)
              row_new[w].rank = row_q[w].rank - hbbc_pkg::RANK_W'(1);
          row_new[hnd_way].rank = hbbc_pkg::RANK_W'(hbbc_pkg::WAYS - 1);
        end
      end
      row_new[hnd_way].cnt = c;
      res_d[14:7] = c;
    end
  end

  assign res_o       = res_q;
  assign stat_o.done = done_q;

  // result register follows every execute step
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.exec |=> done_q)
    else $error("done missing after exec");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.load |-> !cmd_i.exec)
    else $error("load and exec together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q[16:15] != 2'd3)
    else $error("bad status code");
endmodule

@@ rtl/core/hbbc_ctrl.sv @@
// Controller: sequences load, execute and output beat for each request.
// Depends on hbbc_pkg.
`timescale 1ns / 1ps
module hbbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hbbc_pkg::cmd_t  cmd_o,
  input  hbbc_pkg::stat_t stat_i
);
  hbbc_pkg::ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hbbc_pkg::S_IDLE: if (in_valid_i) state_d = hbbc_pkg::S_EXEC;
      hbbc_pkg::S_EXEC: state_d = hbbc_pkg::S_OUT;
      hbbc_pkg::S_OUT:  if (out_ready_i && stat_i.done) state_d = hbbc_pkg::S_IDLE;
      default:          state_d = hbbc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      hbbc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      hbbc_pkg::S_EXEC: cmd_o.exec = 1'b1;
      hbbc_pkg::S_OUT:  out_valid_o = stat_i.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hbbc_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == hbbc_pkg::S_EXEC)
    else $error("load not followed by exec");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hbbc_pkg::S_EXEC |=> out_valid_o)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("accepting while result pending");
endmodule

@@ bench/testbench.sv @@
// Testbench for the hashed block buffer cache core: directed and random
// get/release/pin/unpin traffic checked against a behavioral cache model.
// Depends on hbbc_pkg and hashed_block_buffer_cache_core.
`timescale 1ns / 1ps
module testbench;
  // packed from the top bit down: status, count, needs_read, hit, handle
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cnt;
    logic       rd;
    logic       hit;
    logic [4:0] handle;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  hashed_block_buffer_cache_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cache model state
  logic [7:0]  mdl_dev  [hbbc_pkg::ENTRIES];
  logic [23:0] mdl_blk  [hbbc_pkg::ENTRIES];
  logic [7:0]  mdl_cnt  [hbbc_pkg::ENTRIES];
  logic        mdl_valid[hbbc_pkg::ENTRIES];
  int unsigned mdl_rank [hbbc_pkg::ENTRIES];

  reply_t      pending_replies[$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  bit          stall_rx = 1'b0;
  int          rx_hold = 0;

  // Recently used tags, reused to force hits
  logic [7:0]  seen_dev[$];
  logic [23:0] seen_blk[$];

  task automatic reset_model();
    for (int i = 0; i < hbbc_pkg::ENTRIES; i++) begin
      mdl_dev[i] = '0; mdl_blk[i] = '0; mdl_cnt[i] = '0;
      mdl_valid[i] = 1'b0; mdl_rank[i] = i % hbbc_pkg::WAYS;
    end
  endtask

  function automatic reply_t predict_cache(hbbc_pkg::op_e op, logic [7:0] dev,
                                           logic [23:0] blk, logic [4:0] h);
    reply_t r;
    int set, base, pick, e, r0;
    r = '0;
    if (op == hbbc_pkg::OP_GET) begin
      set = (int'(dev) + int'(blk)) % hbbc_pkg::SETS;
      base = set * hbbc_pkg::WAYS;
      pick = -1;
      for (int w = 0; w < hbbc_pkg::WAYS; w++)
        if (mdl_dev[base+w] == dev && mdl_blk[base+w] == blk &&
            (pick < 0 || mdl_rank[base+w] > mdl_rank[base+pick])) pick = w;
      if (pick >= 0) begin
        e = base + pick;
        r.handle = 5'(e); r.hit = 1'b1; r.rd = !mdl_valid[e];
        if (mdl_cnt[e] == hbbc_pkg::COUNT_MAX) r.status = hbbc_pkg::ST_COUNT;
        else mdl_cnt[e]++;
        mdl_valid[e] = 1'b1;
        r.cnt = mdl_cnt[e];
        return r;
      end
      for (int w = 0; w < hbbc_pkg::WAYS; w++)
        if (mdl_cnt[base+w] == 0 &&
            (pick < 0 || mdl_rank[base+w] < mdl_rank[base+pick])) pick = w;
      if (pick < 0) begin
        r.status = hbbc_pkg::ST_NO_BUF;
        return r;
      end
      e = base + pick;
      mdl_dev[e] = dev; mdl_blk[e] = blk; mdl_cnt[e] = 8'd1; mdl_valid[e] = 1'b1;
      r.handle = 5'(e); r.rd = 1'b1; r.cnt = 8'd1;
      return r;
    end
    r.handle = h;
    if (h >= hbbc_pkg::ENTRIES) begin
      r.status = hbbc_pkg::ST_NO_BUF;
      return r;
    end
    if (op == hbbc_pkg::OP_PIN) begin
      if (mdl_cnt[h] == hbbc_pkg::COUNT_MAX) r.status = hbbc_pkg::ST_COUNT;
      else mdl_cnt[h]++;
    end else if (mdl_cnt[h] == 0) begin
      r.status = hbbc_pkg::ST_COUNT;
    end else begin
      mdl_cnt[h]--;
      if (op == hbbc_pkg::OP_RELEASE && mdl_cnt[h] == 0) begin
        base = (h / hbbc_pkg::WAYS) * hbbc_pkg::WAYS;
        r0 = mdl_rank[h];
        for (int w = 0; w < hbbc_pkg::WAYS; w++)
          if (mdl_rank[base+w] > r0) mdl_rank[base+w]--;
        mdl_rank[h] = hbbc_pkg::WAYS - 1;
      end
    end
    r.cnt = mdl_cnt[h];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one request beat; prediction is made when the beat is accepted
  task automatic send_request(hbbc_pkg::op_e op, logic [7:0] dev, logic [23:0] blk,
                              logic [4:0] h);
    int gap;
    s_axis_tdata  <= {1'b0, h, blk, dev, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(predict_cache(op, dev, blk, h));
    if (op == hbbc_pkg::OP_GET) begin
      seen_dev.push_back(dev); seen_blk.push_back(blk);
      if (seen_dev.size() > 40) begin
        void'(seen_dev.pop_front()); void'(seen_blk.pop_front());
      end
    end
    @(negedge clk_i);
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    reply_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[16:0];
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.handle !== want.handle) report_mismatch("handle", got.handle, want.handle);
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.rd !== want.rd) report_mismatch("needs_read", got.rd, want.rd);
        if (got.cnt !== want.cnt) report_mismatch("ref_count", got.cnt, want.cnt);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Receiver back-pressure: stalls of random length, mostly short
  always @(negedge clk_i) begin
    if (!stall_rx) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_hold = gap_len();
      m_axis_tready <= (rx_hold == 0);
      if (rx_hold != 0) rx_hold--;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_reset_tags();
    // all tags are (0,0) at reset: get of (0,0) hits an invalid entry
    send_request(hbbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0);
  endtask

  task automatic test_count_errors();
    send_request(hbbc_pkg::OP_UNPIN, 8'd0, 24'd0, 5'd5);
    send_request(hbbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd4);
    send_request(hbbc_pkg::OP_PIN, 8'd0, 24'd0, 5'd25);
    send_request(hbbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd1);
    send_request(hbbc_pkg::OP_UNPIN, 8'd0, 24'd0, 5'd1);
    // handles outside the store
    send_request(hbbc_pkg::OP_PIN, 8'hFF, 24'hFFFFFF, 5'd26);
    send_request(hbbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd31);
  endtask

  task automatic test_set_full();
    // get (255,0xFFFFFF) twice; (255,0xFFFFF2) takes the other way
    send_request(hbbc_pkg::OP_GET, 8'hFF, 24'hFFFFFF, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'hFE, 24'hFFFFFF, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'hFF, 24'hFFFFFF, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'h0C, 24'hFFFFFF, 5'd0);
    send_request(hbbc_pkg::OP_GET, 8'hFF, 24'hFFFFF2, 5'd0);
  endtask

  task automatic test_count_saturation();
    // (0,1) lands in entry 2; pin it to the maximum, pin once more,
    // then hit it at the maximum
    send_request(hbbc_pkg::OP_GET, 8'd0, 24'd1, 5'd0);
    for (int i = 0; i < 255; i++) send_request(hbbc_pkg::OP_PIN, 8'd0, 24'd0, 5'd2);
    send_request(hbbc_pkg::OP_GET, 8'd0, 24'd1, 5'd0);
    for (int i = 0; i < 4; i++) send_request(hbbc_pkg::OP_UNPIN, 8'd0, 24'd0, 5'd2);
  endtask

  task automatic test_random_traffic();
    hbbc_pkg::op_e op;
    logic [7:0]  dev;
    logic [23:0] blk;
    logic [4:0]  h;
    int k;
    stall_rx = 1'b1;
    for (int i = 0; i < 230; i++) begin
      op = hbbc_pkg::op_e'($urandom_range(0, 3));
      dev = 8'($urandom); blk = 24'($urandom);
      h = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
                                       : 5'($urandom_range(0, hbbc_pkg::ENTRIES - 1));
      if (op == hbbc_pkg::OP_GET) begin
        k = $urandom_range(0, 9);
        if (k < 5 && seen_dev.size() > 0) begin
          k = $urandom_range(0, seen_dev.size() - 1);
          dev = seen_dev[k]; blk = seen_blk[k];
        end else if (k < 7) begin
          dev = 8'($urandom_range(0, 3)); blk = 24'($urandom_range(0, 40));
        end
      end
      send_request(op, dev, blk, h);
    end
    stall_rx = 1'b0;
  endtask

  initial begin
    int guard;
    reset_model();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_tags();
    test_count_errors();
    test_set_full();
    test_count_saturation();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_replies.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ hashed_block_buffer_cache_core.f @@
rtl/core/hbbc_pkg.sv
rtl/core/hbbc_datapath.sv
rtl/core/hbbc_ctrl.sv
rtl/core/hashed_block_buffer_cache_core.sv
bench/testbench.sv
